// File: sv/csfw_pkg.sv
package csfw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int COUNT_BITS  = 8;

  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int PID_W      = 8;
  localparam int INIT_W     = 8;
  localparam int EV_W       = 3;
  localparam int OUT_ID_W   = 8;

  localparam logic [OP_W-1:0] OP_WAIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_POST    = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [EV_W-1:0] EV_IGNORED   = 3'd0;
  localparam logic [EV_W-1:0] EV_GRANTED   = 3'd1;
  localparam logic [EV_W-1:0] EV_BLOCKED   = 3'd2;
  localparam logic [EV_W-1:0] EV_COUNTUP   = 3'd3;
  localparam logic [EV_W-1:0] EV_WOKE      = 3'd4;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd5;
  localparam logic [EV_W-1:0] EV_SATURATED = 3'd6;
  localparam logic [EV_W-1:0] EV_NONE      = 3'd7;

  typedef struct packed {
    logic push;
    logic pop;
    logic walk_first;
    logic walk_next;
    logic clear;
  } q_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic               walk_last;
    logic [ID_BITS-1:0] rdata;
  } q_stat_t;

  typedef struct packed {
    logic inc;
    logic dec;
    logic load;
  } cnt_cmd_t;

  typedef struct packed {
    logic zero;
    logic at_max;
  } cnt_stat_t;

endpackage

// File: sv/csfw_queue.sv
module csfw_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csfw_pkg::q_cmd_t       cmd_i,
  input  logic [csfw_pkg::ID_BITS-1:0] wdata_i,
  output csfw_pkg::q_stat_t      stat_o
);
  import csfw_pkg::*;

  logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [PTR_W-1:0]   walk_q, walk_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [FILL_W-1:0]  remain_q, remain_d;
  logic [ID_BITS-1:0] rdata_q;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   tail_m1;
  logic               rd_en;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
  endfunction

  assign tail_m1 = ptr_dec(tail_q);
  assign rd_en   = cmd_i.pop | cmd_i.walk_first | cmd_i.walk_next;

  always_comb begin
    if (cmd_i.pop) begin
      rd_addr = head_q;
    end else if (cmd_i.walk_first) begin
      rd_addr = tail_m1;
    end else begin
      rd_addr = walk_q;
    end
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    walk_d   = walk_q;
    remain_d = remain_q;
    if (cmd_i.clear) begin
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
    end else if (cmd_i.push) begin
      tail_d = ptr_inc(tail_q);
      fill_d = fill_q + FILL_W'(1);
    end else if (cmd_i.pop) begin
      head_d = ptr_inc(head_q);
      fill_d = fill_q - FILL_W'(1);
    end
    // The walk runs newest-first from the tail without touching the queue.
    if (cmd_i.walk_first) begin
      walk_d   = ptr_dec(tail_m1);
      remain_d = fill_q;
    end else if (cmd_i.walk_next) begin
      walk_d   = ptr_dec(walk_q);
      remain_d = remain_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      walk_q   <= '0;
      remain_q <= '0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      walk_q   <= walk_d;
      remain_q <= remain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign stat_o.empty     = (fill_q == '0);
  assign stat_o.full      = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign stat_o.walk_last = (remain_q == FILL_W'(1));
  assign stat_o.rdata     = rdata_q;

endmodule

// File: sv/csfw_count.sv
module csfw_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [csfw_pkg::INIT_W-1:0]  cfg_wdata_i,
  input  csfw_pkg::cnt_cmd_t           cmd_i,
  output csfw_pkg::cnt_stat_t          stat_o
);
  import csfw_pkg::*;

  logic [INIT_W-1:0]     init_q;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] delta;
  logic [COUNT_BITS-1:0] sum;

  // One adder serves both directions: minus one is all ones.
  assign delta = cmd_i.dec ? '1 : COUNT_BITS'(1);
  assign sum   = count_q + delta;

  always_comb begin
    count_d = count_q;
    if (cmd_i.load) begin
      count_d = COUNT_BITS'(init_q);
    end else if (cmd_i.inc || cmd_i.dec) begin
      count_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  assign stat_o.zero   = (count_q == '0);
  assign stat_o.at_max = (count_q == '1);

endmodule

// File: sv/counting_semaphore_fifo_waiters.sv
// Flow: an accepted wait or post is decided in the DECIDE state and its result
// is strobed from a register; a post that wakes a waiter passes through POP.
// A new transaction is taken only while idle; a release of n waiters strobes
// its wake results back to back, paced by the single queue memory read port.
// Reset clears the count, the queue pointers and the initial count at once.
// Results cannot be stalled: each one is shown for exactly one cycle.
module counting_semaphore_fifo_waiters (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [csfw_pkg::OP_W-1:0]     operation_i,
  input  logic [csfw_pkg::PID_W-1:0]    process_id_i,
  input  logic                          in_thread_mode_i,
  input  logic                          cfg_we_i,
  input  logic [csfw_pkg::INIT_W-1:0]   cfg_wdata_i,
  output logic                          res_strobe_o,
  output logic [csfw_pkg::EV_W-1:0]     event_res_o,
  output logic [csfw_pkg::OUT_ID_W-1:0] woken_id_o,
  output logic                          switch_request_o,
  output logic                          last_o
);
  import csfw_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_POP    = 2'd2;
  localparam logic [1:0] S_WALK   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [OP_W-1:0]    op_q;
  logic [ID_BITS-1:0] pid_q;
  logic               thread_q;

  logic               emit;
  logic [EV_W-1:0]    ev_d;
  logic [ID_BITS-1:0] id_d;
  logic               sw_d, last_d;

  logic               strobe_q;
  logic [EV_W-1:0]    ev_q;
  logic [ID_BITS-1:0] id_q;
  logic               sw_q, last_q;

  q_cmd_t    q_cmd;
  q_stat_t   q_stat;
  cnt_cmd_t  c_cmd;
  cnt_stat_t c_stat;

  logic accept;
  assign accept = start && (state_q == S_IDLE);

  csfw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (q_cmd),
    .wdata_i (pid_q),
    .stat_o  (q_stat)
  );

  csfw_count u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (c_cmd),
    .stat_o      (c_stat)
  );

  always_comb begin
    state_d = state_q;
    q_cmd   = '0;
    c_cmd   = '0;
    emit    = 1'b0;
    ev_d    = EV_IGNORED;
    id_d    = '0;
    sw_d    = 1'b0;
    last_d  = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (op_q)
          OP_RELEASE: begin
            if (q_stat.empty) begin
              emit        = 1'b1;
              ev_d        = EV_NONE;
              q_cmd.clear = 1'b1;
              c_cmd.load  = 1'b1;
            end else begin
              q_cmd.walk_first = 1'b1;
              state_d          = S_WALK;
            end
          end
          OP_WAIT: begin
            emit = 1'b1;
            if (!thread_q) begin
              ev_d = EV_IGNORED;
            end else if (!c_stat.zero) begin
              ev_d      = EV_GRANTED;
              c_cmd.dec = 1'b1;
            end else if (q_stat.full) begin
              ev_d = EV_FULL;
              id_d = pid_q;
            end else begin
              ev_d       = EV_BLOCKED;
              id_d       = pid_q;
              sw_d       = 1'b1;
              q_cmd.push = 1'b1;
            end
          end
          OP_POST: begin
            if (!thread_q) begin
              emit = 1'b1;
              ev_d = EV_IGNORED;
            end else if (!q_stat.empty) begin
              q_cmd.pop = 1'b1;
              state_d   = S_POP;
            end else if (c_stat.at_max) begin
              emit = 1'b1;
              ev_d = EV_SATURATED;
            end else begin
              emit      = 1'b1;
              ev_d      = EV_COUNTUP;
              c_cmd.inc = 1'b1;
            end
          end
          default: begin
            emit = 1'b1;
            ev_d = EV_IGNORED;
          end
        endcase
      end
      S_POP: begin
        emit    = 1'b1;
        ev_d    = EV_WOKE;
        id_d    = q_stat.rdata;
        sw_d    = 1'b1;
        state_d = S_IDLE;
      end
      S_WALK: begin
        emit   = 1'b1;
        ev_d   = EV_WOKE;
        id_d   = q_stat.rdata;
        last_d = q_stat.walk_last;
        if (q_stat.walk_last) begin
          q_cmd.clear = 1'b1;
          c_cmd.load  = 1'b1;
          state_d     = S_IDLE;
        end else begin
          q_cmd.walk_next = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      pid_q    <= process_id_i[ID_BITS-1:0];
      thread_q <= in_thread_mode_i;
    end
    if (emit) begin
      ev_q   <= ev_d;
      id_q   <= id_d;
      sw_q   <= sw_d;
      last_q <= last_d;
    end
  end

  assign busy             = (state_q != S_IDLE);
  assign res_strobe_o     = strobe_q;
  assign event_res_o      = ev_q;
  assign woken_id_o       = OUT_ID_W'(id_q);
  assign switch_request_o = sw_q;
  assign last_o           = last_q;

endmodule

// File: sv/csfw_checker.sv
module csfw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          res_strobe_o,
  input logic [csfw_pkg::EV_W-1:0]     event_res_o,
  input logic                          switch_request_o,
  input logic                          last_o
);
  import csfw_pkg::*;

  // An accepted transaction always occupies the block for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepting a transaction");

  // A release walk delivers its wake results back to back.
  a_walk_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |=> res_strobe_o)
    else $error("gap inside a multi-result transaction");

  // Only wake results of a release walk come without the last mark.
  a_not_last_is_woke: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |-> event_res_o == EV_WOKE && busy && !switch_request_o)
    else $error("non-final result that is not a release wake");

  // The final result of a transaction frees the block.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy)
    else $error("block still busy on the final result");

  // A context switch is asked for only when a process blocks or wakes.
  a_switch_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && switch_request_o |-> event_res_o == EV_BLOCKED || event_res_o == EV_WOKE)
    else $error("switch requested on an unexpected event");

endmodule

bind counting_semaphore_fifo_waiters csfw_checker u_csfw_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .res_strobe_o     (res_strobe_o),
  .event_res_o      (event_res_o),
  .switch_request_o (switch_request_o),
  .last_o           (last_o)
);
